// ===== src/qbte_pkg.sv =====
// Shared widths, types, register codes and coefficient tables of the quintic blend evaluator.
package qbte_pkg;

   localparam int FRAC_BITS_DEFAULT = 16;

   localparam int DATA_W    = 32;
   localparam int T_W       = DATA_W + 1;
   localparam int ACC_W     = 63;
   localparam int MAG_W     = ACC_W - 1;
   localparam int HALF_W    = MAG_W / 2;
   localparam int MUL_W     = HALF_W + T_W;
   localparam int PROD_W    = MAG_W + T_W;
   localparam int LANES     = 3;
   localparam int TAPS      = 6;
   localparam int STEPS     = TAPS - 1;
   localparam int TERMS     = 3;
   localparam int NUM_REGS  = 8;
   localparam int REG_IDX_W = 3;

   localparam int LANE_POS = 0;
   localparam int LANE_VEL = 1;
   localparam int LANE_ACC = 2;

   localparam int TERM_POS_DIFF   = 0;
   localparam int TERM_RATE_DIFF  = 1;
   localparam int TERM_ACCEL_DIFF = 2;

   typedef enum logic [REG_IDX_W-1:0] {
      REG_START_TIME     = 3'd0,
      REG_END_TIME       = 3'd1,
      REG_START_POSITION = 3'd2,
      REG_START_RATE     = 3'd3,
      REG_START_ACCEL    = 3'd4,
      REG_END_POSITION   = 3'd5,
      REG_END_RATE       = 3'd6,
      REG_END_ACCEL      = 3'd7
   } qbte_reg_type;

   typedef logic [LANES-1:0][ACC_W-1:0] qbte_lanes_type;
   typedef logic [TAPS-1:0][LANES-1:0][ACC_W-1:0] qbte_coef_type;

   // Per-transaction context that rides along with the accumulators.
   typedef struct packed {
      logic [T_W-1:0] t_mag;
      logic           t_neg;
      logic           in_domain;
   } qbte_ctx_type;

   localparam logic [ACC_W-1:0] ACC_POS_LIM = {1'b0, {MAG_W{1'b1}}};
   localparam logic [ACC_W-1:0] ACC_NEG_LIM = {1'b1, {(MAG_W-1){1'b0}}, 1'b1};

   // Weights on (position diff, rate diff, accel diff) for every Horner tap of every lane,
   // highest power first. Velocity and acceleration lanes are padded with leading zero taps
   // so that all three lanes run the same number of steps.
   localparam int COEF_K [LANES][TAPS][TERMS] = '{
      '{ '{-37500, -3750, -125}, '{18750, 2000, 75}, '{-2500, -300, -15},
         '{0, 0, 1}, '{0, 2, 0}, '{2, 0, 0} },
      '{ '{0, 0, 0}, '{-187500, -18750, -625}, '{75000, 8000, 300},
         '{-7500, -900, -45}, '{0, 0, 2}, '{0, 2, 0} },
      '{ '{0, 0, 0}, '{0, 0, 0}, '{-750000, -75000, -2500},
         '{225000, 24000, 900}, '{-15000, -1800, -90}, '{0, 0, 2} }
   };

   // Clamp a 64-bit signed sum to the symmetric accumulator range.
   function automatic logic [ACC_W-1:0] sat_acc(input logic [ACC_W:0] sum);
      logic [ACC_W-1:0] res;
      res = sum[ACC_W-1:0];
      if (!sum[ACC_W] && sum[ACC_W-1]) begin
         res = ACC_POS_LIM;
      end else if (sum[ACC_W] && !sum[ACC_W-1]) begin
         res = ACC_NEG_LIM;
      end else if (sum[ACC_W] && sum[ACC_W-1] && (sum[ACC_W-2:0] == '0)) begin
         res = ACC_NEG_LIM;
      end
      return res;
   endfunction

endpackage

// ===== src/qbte_coef.sv =====
// Configuration registers and the registered polynomial coefficients derived from them.
module qbte_coef (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_wr_en,
   input  logic [qbte_pkg::REG_IDX_W-1:0]        csr_index,
   input  logic [qbte_pkg::DATA_W-1:0]           csr_wdata,
   output logic [qbte_pkg::DATA_W-1:0]           start_time,
   output logic [qbte_pkg::DATA_W-1:0]           end_time,
   output qbte_pkg::qbte_coef_type               coef
);

   logic [qbte_pkg::NUM_REGS-1:0][qbte_pkg::DATA_W-1:0] regs_ff, regs_in;
   qbte_pkg::qbte_coef_type                              coef_ff, coef_in;
   logic signed [qbte_pkg::T_W-1:0]                      diff_pos, diff_rate, diff_accel;

   always_comb begin
      regs_in = regs_ff;
      if (csr_wr_en) begin
         regs_in[csr_index] = csr_wdata;
      end
   end

   assign diff_pos =
      qbte_pkg::T_W'($signed(regs_ff[qbte_pkg::REG_START_POSITION])) -
      qbte_pkg::T_W'($signed(regs_ff[qbte_pkg::REG_END_POSITION]));
   assign diff_rate =
      qbte_pkg::T_W'($signed(regs_ff[qbte_pkg::REG_START_RATE])) -
      qbte_pkg::T_W'($signed(regs_ff[qbte_pkg::REG_END_RATE]));
   assign diff_accel =
      qbte_pkg::T_W'($signed(regs_ff[qbte_pkg::REG_START_ACCEL])) -
      qbte_pkg::T_W'($signed(regs_ff[qbte_pkg::REG_END_ACCEL]));

   // Every weight is a constant, so each term reduces to a shift-and-add network.
   always_comb begin
      for (int tap = 0; tap < qbte_pkg::TAPS; tap++) begin
         for (int lane = 0; lane < qbte_pkg::LANES; lane++) begin
            coef_in[tap][lane] =
               qbte_pkg::ACC_W'(diff_pos) *
               qbte_pkg::ACC_W'(qbte_pkg::COEF_K[lane][tap][qbte_pkg::TERM_POS_DIFF]) +
               qbte_pkg::ACC_W'(diff_rate) *
               qbte_pkg::ACC_W'(qbte_pkg::COEF_K[lane][tap][qbte_pkg::TERM_RATE_DIFF]) +
               qbte_pkg::ACC_W'(diff_accel) *
               qbte_pkg::ACC_W'(qbte_pkg::COEF_K[lane][tap][qbte_pkg::TERM_ACCEL_DIFF]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff <= '0;
         coef_ff <= '0;
      end else begin
         regs_ff <= regs_in;
         coef_ff <= coef_in;
      end
   end

   assign start_time = regs_ff[qbte_pkg::REG_START_TIME];
   assign end_time   = regs_ff[qbte_pkg::REG_END_TIME];
   assign coef       = coef_ff;

endmodule

// ===== src/qbte_step.sv =====
// One Horner step (acc * t rounded, plus coefficient, saturated) for all three lanes.
module qbte_step #(
   parameter int FRAC_BITS = qbte_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  qbte_pkg::qbte_ctx_type   in_ctx,
   input  qbte_pkg::qbte_lanes_type in_acc,
   input  qbte_pkg::qbte_lanes_type coef,
   output logic                     out_valid,
   input  logic                     out_ready,
   output qbte_pkg::qbte_ctx_type   out_ctx,
   output qbte_pkg::qbte_lanes_type out_acc
);

   localparam logic [qbte_pkg::PROD_W-1:0] RND =
      qbte_pkg::PROD_W'(1) << (FRAC_BITS - 1);

   logic abs_valid_ff, abs_valid_in, abs_ready;
   logic mul_valid_ff, mul_valid_in, mul_ready;
   logic sum_valid_ff, sum_valid_in, sum_ready;
   logic acc_valid_ff, acc_valid_in, acc_ready;

   qbte_pkg::qbte_ctx_type abs_ctx_ff, mul_ctx_ff, sum_ctx_ff, acc_ctx_ff;

   logic [qbte_pkg::LANES-1:0][qbte_pkg::ACC_W-1:0]  acc_negated;
   logic [qbte_pkg::LANES-1:0][qbte_pkg::MAG_W-1:0]  abs_mag_ff, abs_mag_in;
   logic [qbte_pkg::LANES-1:0]                       abs_neg_ff, abs_neg_in;
   logic [qbte_pkg::LANES-1:0][qbte_pkg::MUL_W-1:0]  mul_lo_ff, mul_lo_in;
   logic [qbte_pkg::LANES-1:0][qbte_pkg::MUL_W-1:0]  mul_hi_ff, mul_hi_in;
   logic [qbte_pkg::LANES-1:0]                       mul_neg_ff;
   logic [qbte_pkg::LANES-1:0][qbte_pkg::PROD_W-1:0] sum_prod_ff, sum_prod_in;
   logic [qbte_pkg::LANES-1:0]                       sum_neg_ff;
   logic [qbte_pkg::LANES-1:0][qbte_pkg::PROD_W-1:0] prod_shift;
   logic [qbte_pkg::LANES-1:0][qbte_pkg::MAG_W-1:0]  prod_mag;
   logic [qbte_pkg::LANES-1:0][qbte_pkg::ACC_W-1:0]  prod_signed;
   logic [qbte_pkg::LANES-1:0][qbte_pkg::ACC_W-1:0]  acc_val_ff, acc_val_in;

   // A stage takes new data when it is empty or its successor moves.
   assign acc_ready = !acc_valid_ff || out_ready;
   assign sum_ready = !sum_valid_ff || acc_ready;
   assign mul_ready = !mul_valid_ff || sum_ready;
   assign abs_ready = !abs_valid_ff || mul_ready;
   assign in_ready  = abs_ready;

   assign abs_valid_in = abs_ready ? in_valid     : abs_valid_ff;
   assign mul_valid_in = mul_ready ? abs_valid_ff : mul_valid_ff;
   assign sum_valid_in = sum_ready ? mul_valid_ff : sum_valid_ff;
   assign acc_valid_in = acc_ready ? sum_valid_ff : acc_valid_ff;

   always_comb begin
      for (int l = 0; l < qbte_pkg::LANES; l++) begin
         // Sign and magnitude of the running value.
         acc_negated[l] = -in_acc[l];
         abs_mag_in[l]  = in_acc[l][qbte_pkg::ACC_W-1] ? acc_negated[l][qbte_pkg::MAG_W-1:0]
                                                       : in_acc[l][qbte_pkg::MAG_W-1:0];
         abs_neg_in[l]  = in_acc[l][qbte_pkg::ACC_W-1] ^ in_ctx.t_neg;

         // Two 31 x 33 partial products of the magnitudes.
         mul_lo_in[l] = qbte_pkg::MUL_W'(abs_mag_ff[l][qbte_pkg::HALF_W-1:0]) *
                        qbte_pkg::MUL_W'(abs_ctx_ff.t_mag);
         mul_hi_in[l] = qbte_pkg::MUL_W'(abs_mag_ff[l][qbte_pkg::MAG_W-1:qbte_pkg::HALF_W]) *
                        qbte_pkg::MUL_W'(abs_ctx_ff.t_mag);

         // Full product plus the half LSB, so the shift rounds half away from zero.
         sum_prod_in[l] = (qbte_pkg::PROD_W'(mul_hi_ff[l]) << qbte_pkg::HALF_W) +
                          qbte_pkg::PROD_W'(mul_lo_ff[l]) + RND;

         prod_shift[l] = sum_prod_ff[l] >> FRAC_BITS;
         prod_mag[l]   = (|prod_shift[l][qbte_pkg::PROD_W-1:qbte_pkg::MAG_W])
                         ? {qbte_pkg::MAG_W{1'b1}} : prod_shift[l][qbte_pkg::MAG_W-1:0];
         prod_signed[l] = sum_neg_ff[l] ? -{1'b0, prod_mag[l]} : {1'b0, prod_mag[l]};
         acc_val_in[l]  = qbte_pkg::sat_acc(
            {prod_signed[l][qbte_pkg::ACC_W-1], prod_signed[l]} +
            {coef[l][qbte_pkg::ACC_W-1], coef[l]});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         abs_valid_ff <= 1'b0;
         mul_valid_ff <= 1'b0;
         sum_valid_ff <= 1'b0;
         acc_valid_ff <= 1'b0;
      end else begin
         abs_valid_ff <= abs_valid_in;
         mul_valid_ff <= mul_valid_in;
         sum_valid_ff <= sum_valid_in;
         acc_valid_ff <= acc_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (abs_ready) begin
         abs_ctx_ff <= in_ctx;
         abs_mag_ff <= abs_mag_in;
         abs_neg_ff <= abs_neg_in;
      end
      if (mul_ready) begin
         mul_ctx_ff <= abs_ctx_ff;
         mul_lo_ff  <= mul_lo_in;
         mul_hi_ff  <= mul_hi_in;
         mul_neg_ff <= abs_neg_ff;
      end
      if (sum_ready) begin
         sum_ctx_ff  <= mul_ctx_ff;
         sum_prod_ff <= sum_prod_in;
         sum_neg_ff  <= mul_neg_ff;
      end
      if (acc_ready) begin
         acc_ctx_ff <= sum_ctx_ff;
         acc_val_ff <= acc_val_in;
      end
   end

   assign out_valid = acc_valid_ff;
   assign out_ctx   = acc_ctx_ff;
   assign out_acc   = acc_val_ff;

   a_reset_empties: assert property (@(posedge clock)
      reset |=> !(abs_valid_ff || mul_valid_ff || sum_valid_ff || acc_valid_ff))
      else $error("step pipeline not empty after reset");

   a_accept_fills_entry: assert property (@(posedge clock) disable iff (reset)
      in_valid && in_ready |=> abs_valid_ff)
      else $error("accepted transaction did not enter the step pipeline");

   a_stalled_result_holds: assert property (@(posedge clock) disable iff (reset)
      acc_valid_ff && !out_ready |=> acc_valid_ff && $stable(acc_val_ff))
      else $error("step result changed while held by the next stage");

endmodule

// ===== src/qbte_finish.sv =====
// Final rounding to the output fraction width and 32-bit saturation, with the output register.
module qbte_finish (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          in_valid,
   output logic                                          in_ready,
   input  qbte_pkg::qbte_lanes_type                      in_acc,
   input  logic                                          in_dom,
   output logic                                          out_valid,
   input  logic                                          out_ready,
   output logic [qbte_pkg::LANES-1:0][qbte_pkg::DATA_W-1:0] out_value,
   output logic                                          out_dom
);

   localparam logic [qbte_pkg::DATA_W-1:0] OUT_MAX = {1'b0, {(qbte_pkg::DATA_W-1){1'b1}}};
   localparam logic [qbte_pkg::DATA_W-1:0] OUT_MIN = {1'b1, {(qbte_pkg::DATA_W-1){1'b0}}};

   logic abs_valid_ff, abs_valid_in, abs_ready;
   logic rnd_valid_ff, rnd_valid_in, rnd_ready;
   logic out_valid_ff, out_valid_in, out_ready_int;
   logic abs_dom_ff, rnd_dom_ff, out_dom_ff;

   logic [qbte_pkg::LANES-1:0][qbte_pkg::ACC_W-1:0]  acc_negated;
   logic [qbte_pkg::LANES-1:0][qbte_pkg::MAG_W-1:0]  abs_mag_ff, abs_mag_in;
   logic [qbte_pkg::LANES-1:0]                       abs_neg_ff, abs_neg_in;
   logic [qbte_pkg::LANES-1:0][qbte_pkg::MAG_W:0]    rnd_sum;
   logic [qbte_pkg::LANES-1:0][qbte_pkg::MAG_W-1:0]  rnd_full;
   logic [qbte_pkg::LANES-1:0][qbte_pkg::DATA_W-1:0] rnd_mag_ff, rnd_mag_in;
   logic [qbte_pkg::LANES-1:0]                       rnd_over_ff, rnd_over_in;
   logic [qbte_pkg::LANES-1:0]                       rnd_neg_ff;
   logic [qbte_pkg::LANES-1:0][qbte_pkg::DATA_W-1:0] out_val_ff, out_val_in;

   assign out_ready_int = !out_valid_ff || out_ready;
   assign rnd_ready     = !rnd_valid_ff || out_ready_int;
   assign abs_ready     = !abs_valid_ff || rnd_ready;
   assign in_ready      = abs_ready;

   assign abs_valid_in = abs_ready     ? in_valid     : abs_valid_ff;
   assign rnd_valid_in = rnd_ready     ? abs_valid_ff : rnd_valid_ff;
   assign out_valid_in = out_ready_int ? rnd_valid_ff : out_valid_ff;

   always_comb begin
      for (int l = 0; l < qbte_pkg::LANES; l++) begin
         acc_negated[l] = -in_acc[l];
         abs_mag_in[l]  = in_acc[l][qbte_pkg::ACC_W-1] ? acc_negated[l][qbte_pkg::MAG_W-1:0]
                                                       : in_acc[l][qbte_pkg::MAG_W-1:0];
         abs_neg_in[l]  = in_acc[l][qbte_pkg::ACC_W-1];

         // Drop the extra fraction bit, rounding half away from zero on the magnitude.
         rnd_sum[l]  = {1'b0, abs_mag_ff[l]} + 1'b1;
         rnd_full[l] = rnd_sum[l][qbte_pkg::MAG_W:1];
         rnd_mag_in[l]  = rnd_full[l][qbte_pkg::DATA_W-1:0];
         rnd_over_in[l] = (|rnd_full[l][qbte_pkg::MAG_W-1:qbte_pkg::DATA_W]) ||
                          (abs_neg_ff[l] ? (rnd_full[l][qbte_pkg::DATA_W-1] &&
                                            (|rnd_full[l][qbte_pkg::DATA_W-2:0]))
                                         : rnd_full[l][qbte_pkg::DATA_W-1]);

         if (rnd_over_ff[l]) begin
            out_val_in[l] = rnd_neg_ff[l] ? OUT_MIN : OUT_MAX;
         end else begin
            out_val_in[l] = rnd_neg_ff[l] ? -rnd_mag_ff[l] : rnd_mag_ff[l];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         abs_valid_ff <= 1'b0;
         rnd_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         abs_valid_ff <= abs_valid_in;
         rnd_valid_ff <= rnd_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (abs_ready) begin
         abs_mag_ff <= abs_mag_in;
         abs_neg_ff <= abs_neg_in;
         abs_dom_ff <= in_dom;
      end
      if (rnd_ready) begin
         rnd_mag_ff  <= rnd_mag_in;
         rnd_over_ff <= rnd_over_in;
         rnd_neg_ff  <= abs_neg_ff;
         rnd_dom_ff  <= abs_dom_ff;
      end
      if (out_ready_int) begin
         out_val_ff <= out_val_in;
         out_dom_ff <= rnd_dom_ff;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_value = out_val_ff;
   assign out_dom   = out_dom_ff;

endmodule

// ===== src/quintic_blend_trajectory_eval_core.sv =====
// Top level of the quintic blend trajectory evaluator: front end, Horner pipeline, output.
//
//   Channel  Direction  Handshake             Payload
//   req      in         req_valid/req_stall   req_query_time (signed Q16.16)
//   rsp      out        rsp_valid/rsp_stall   rsp_position, rsp_velocity, rsp_acceleration,
//                                             rsp_in_domain
//   csr      in         csr_wr_en             csr_index, csr_wdata (write only)
//
// One transaction is accepted per cycle while req_stall is low. On its way to the output
// register a transaction passes through two front-end stages, five Horner steps of four stages
// each (absolute value, split 31x33 multiply, product sum with rounding, add and saturate),
// and three finishing stages. Reset is synchronous and clears every valid bit and all
// configuration registers. While rsp_stall holds a result, the stages behind it keep moving
// until they are full, and req_stall rises only when the whole pipeline is occupied.
module quintic_blend_trajectory_eval_core #(
   parameter int FRAC_BITS = qbte_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [qbte_pkg::DATA_W-1:0]  req_query_time,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [qbte_pkg::DATA_W-1:0]  rsp_position,
   output logic signed [qbte_pkg::DATA_W-1:0]  rsp_velocity,
   output logic signed [qbte_pkg::DATA_W-1:0]  rsp_acceleration,
   output logic                                rsp_in_domain,
   input  logic                                csr_wr_en,
   input  logic [qbte_pkg::REG_IDX_W-1:0]      csr_index,
   input  logic [qbte_pkg::DATA_W-1:0]         csr_wdata
);

   logic [qbte_pkg::DATA_W-1:0] start_time, end_time;
   qbte_pkg::qbte_coef_type     coef;

   // Front end: the first stage forms t = query_time - start_time and the domain flag,
   // the second turns t into sign and magnitude for the multipliers.
   logic                            sub_valid_ff, sub_valid_in, sub_ready;
   logic signed [qbte_pkg::T_W-1:0] sub_t_ff, sub_t_in;
   logic                            sub_dom_ff, sub_dom_in;
   logic                            ctx_valid_ff, ctx_valid_in, ctx_ready;
   qbte_pkg::qbte_ctx_type          ctx_ff, ctx_in;
   logic [qbte_pkg::T_W-1:0]        sub_t_negated;

   // Chain of Horner steps; index 0 feeds the first step.
   logic [qbte_pkg::STEPS:0]  chain_valid, chain_ready;
   qbte_pkg::qbte_ctx_type    chain_ctx [qbte_pkg::STEPS+1];
   qbte_pkg::qbte_lanes_type  chain_acc [qbte_pkg::STEPS+1];

   logic [qbte_pkg::LANES-1:0][qbte_pkg::DATA_W-1:0] fin_value;
   logic                                             fin_dom;

   qbte_coef u_coef (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .start_time (start_time),
      .end_time   (end_time),
      .coef       (coef)
   );

   assign ctx_ready    = !ctx_valid_ff || chain_ready[0];
   assign sub_ready    = !sub_valid_ff || ctx_ready;
   assign req_stall    = !sub_ready;
   assign sub_valid_in = sub_ready ? req_valid    : sub_valid_ff;
   assign ctx_valid_in = ctx_ready ? sub_valid_ff : ctx_valid_ff;

   assign sub_t_in   = qbte_pkg::T_W'(req_query_time) - qbte_pkg::T_W'($signed(start_time));
   assign sub_dom_in = ($signed(start_time) <= req_query_time) &&
                       (req_query_time <= $signed(end_time));

   // |t| never exceeds 2^32, so the magnitude fits the unsigned 33-bit field.
   assign sub_t_negated    = -sub_t_ff;
   assign ctx_in.t_neg     = sub_t_ff[qbte_pkg::T_W-1];
   assign ctx_in.t_mag     = sub_t_ff[qbte_pkg::T_W-1] ? sub_t_negated : sub_t_ff;
   assign ctx_in.in_domain = sub_dom_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sub_valid_ff <= 1'b0;
         ctx_valid_ff <= 1'b0;
      end else begin
         sub_valid_ff <= sub_valid_in;
         ctx_valid_ff <= ctx_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (sub_ready) begin
         sub_t_ff   <= sub_t_in;
         sub_dom_ff <= sub_dom_in;
      end
      if (ctx_ready) begin
         ctx_ff <= ctx_in;
      end
   end

   // The highest coefficient is the starting value of every lane's accumulator.
   // The user must keep configuration quiet while transactions are in flight (the block does
   // not enforce this), so the coefficients can be read straight from their registers by each step.
   assign chain_valid[0] = ctx_valid_ff;
   assign chain_ctx[0]   = ctx_ff;
   assign chain_acc[0]   = coef[0];

   for (genvar s = 0; s < qbte_pkg::STEPS; s++) begin : g_step
      qbte_step #(
         .FRAC_BITS (FRAC_BITS)
      ) u_step (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (chain_valid[s]),
         .in_ready  (chain_ready[s]),
         .in_ctx    (chain_ctx[s]),
         .in_acc    (chain_acc[s]),
         .coef      (coef[s+1]),
         .out_valid (chain_valid[s+1]),
         .out_ready (chain_ready[s+1]),
         .out_ctx   (chain_ctx[s+1]),
         .out_acc   (chain_acc[s+1])
      );
   end

   // Rounding off the extra fraction bit and clamping to 32 bits; its last stage is the
   // output register, which holds the transaction steady while rsp_stall is high.
   qbte_finish u_finish (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (chain_valid[qbte_pkg::STEPS]),
      .in_ready  (chain_ready[qbte_pkg::STEPS]),
      .in_acc    (chain_acc[qbte_pkg::STEPS]),
      .in_dom    (chain_ctx[qbte_pkg::STEPS].in_domain),
      .out_valid (rsp_valid),
      .out_ready (!rsp_stall),
      .out_value (fin_value),
      .out_dom   (fin_dom)
   );

   assign rsp_position     = fin_value[qbte_pkg::LANE_POS];
   assign rsp_velocity     = fin_value[qbte_pkg::LANE_VEL];
   assign rsp_acceleration = fin_value[qbte_pkg::LANE_ACC];
   assign rsp_in_domain    = fin_dom;

endmodule

// ===== tb/quintic_blend_trajectory_eval_core_test.sv =====
// Self-checking testbench for the quintic blend trajectory evaluator core.
`timescale 1ns / 100ps

module quintic_blend_trajectory_eval_core_test;

   // The bench predicts results at the block's default fraction width.
   localparam int FRAC = qbte_pkg::FRAC_BITS_DEFAULT;

   // Intermediate values saturate symmetrically to +-(2^62 - 1).
   localparam longint ACC_LIMIT = 64'sh3FFF_FFFF_FFFF_FFFF;
   localparam longint OUT_MAX   = 64'sd2147483647;
   localparam longint OUT_MIN   = -64'sd2147483648;

   localparam logic signed [qbte_pkg::DATA_W-1:0] S32_MAX    = 32'sh7FFF_FFFF;
   localparam logic signed [qbte_pkg::DATA_W-1:0] S32_MIN    = 32'sh8000_0000;
   localparam logic signed [qbte_pkg::DATA_W-1:0] Q_ONE      = 32'sh0001_0000;
   // Nominal blend span of 0.2 s in Q16.16.
   localparam logic signed [qbte_pkg::DATA_W-1:0] BLEND_SPAN = 32'sd13107;

   localparam int RANDOM_QUERIES = 1850;
   localparam int SETTLE_CYCLES  = 30;
   localparam int DRAIN_LIMIT    = 20000;
   localparam int CYCLE_LIMIT    = 1000000;

   // Traffic shaping for both channels; quiet phases give stretches without idling.
   typedef enum int {
      TRAFFIC_QUIET,
      TRAFFIC_LIGHT,
      TRAFFIC_HEAVY
   } traffic_type;

   typedef logic signed [qbte_pkg::DATA_W-1:0] blend_cfg_type [qbte_pkg::NUM_REGS];

   // One predicted result, tagged with the query that produced it.
   typedef struct {
      logic signed [qbte_pkg::DATA_W-1:0] query;
      logic signed [qbte_pkg::DATA_W-1:0] position;
      logic signed [qbte_pkg::DATA_W-1:0] velocity;
      logic signed [qbte_pkg::DATA_W-1:0] acceleration;
      logic                               in_domain;
   } blend_sample_type;

   // Holds a mirror of the configuration registers and the queue of samples that the
   // block still owes. The kinematics are computed when a query transaction is accepted.
   class blend_checker;
      logic signed [qbte_pkg::DATA_W-1:0] regs [qbte_pkg::NUM_REGS];
      blend_sample_type                   due_samples [$];
      int                                 mismatches;

      function new();
         mismatches = 0;
         foreach (regs[i]) regs[i] = '0;
      endfunction

      task report(string what);
         mismatches++;
         $display("MISMATCH at %0t: %s", $realtime, what);
      endtask

      function void set_reg(qbte_pkg::qbte_reg_type idx, logic [qbte_pkg::DATA_W-1:0] value);
         regs[idx] = value;
      endfunction

      function longint clamp_wide(longint v);
         if (v > ACC_LIMIT) return ACC_LIMIT;
         if (v < -ACC_LIMIT) return -ACC_LIMIT;
         return v;
      endfunction

      // Exact product scaled down by FRAC bits, rounded half away from zero, saturated.
      function longint scaled_product(longint a, longint b);
         logic [63:0]  ua;
         logic [63:0]  ub;
         logic [127:0] p;
         longint       m;
         ua = (a < 0) ? -a : a;
         ub = (b < 0) ? -b : b;
         p = ua * ub + (128'd1 << (FRAC - 1));
         p = p >> FRAC;
         if (p > 128'(ACC_LIMIT)) m = ACC_LIMIT;
         else m = p[63:0];
         return ((a < 0) != (b < 0)) ? -m : m;
      endfunction

      // Horner evaluation, highest power first, over the first n coefficients.
      function longint horner(longint c [6], int n, longint t);
         longint acc;
         int     i;
         acc = clamp_wide(c[0]);
         for (i = 1; i < n; i++) begin
            acc = clamp_wide(scaled_product(acc, t) + clamp_wide(c[i]));
         end
         return acc;
      endfunction

      // Drops the extra fraction bit (half away from zero) and clamps to 32 bits.
      function logic signed [qbte_pkg::DATA_W-1:0] round_out(longint v);
         longint m;
         m = (v < 0) ? -v : v;
         m = (m + 1) >>> 1;
         if (v < 0) m = -m;
         if (m > OUT_MAX) m = OUT_MAX;
         if (m < OUT_MIN) m = OUT_MIN;
         return m[qbte_pkg::DATA_W-1:0];
      endfunction

      // Predicts the kinematics for an accepted query and queues them.
      function void note_query(logic signed [qbte_pkg::DATA_W-1:0] q);
         longint           t, dp, dv, da;
         longint           k5, k4, k3;
         longint           pos_c [6];
         longint           vel_c [6];
         longint           acc_c [6];
         blend_sample_type s;
         t  = longint'(q) - longint'(regs[qbte_pkg::REG_START_TIME]);
         dp = longint'(regs[qbte_pkg::REG_START_POSITION]) -
              longint'(regs[qbte_pkg::REG_END_POSITION]);
         dv = longint'(regs[qbte_pkg::REG_START_RATE]) -
              longint'(regs[qbte_pkg::REG_END_RATE]);
         da = longint'(regs[qbte_pkg::REG_START_ACCEL]) -
              longint'(regs[qbte_pkg::REG_END_ACCEL]);
         // Coefficients carry one fraction bit more than the data.
         k5 = -37500 * dp - 3750 * dv - 125 * da;
         k4 = 18750 * dp + 2000 * dv + 75 * da;
         k3 = -2500 * dp - 300 * dv - 15 * da;
         pos_c = '{k5, k4, k3, da, 2 * dv, 2 * dp};
         vel_c = '{5 * k5, 4 * k4, 3 * k3, 2 * da, 2 * dv, 0};
         acc_c = '{20 * k5, 12 * k4, 6 * k3, 2 * da, 0, 0};
         s.query        = q;
         s.position     = round_out(horner(pos_c, 6, t));
         s.velocity     = round_out(horner(vel_c, 5, t));
         s.acceleration = round_out(horner(acc_c, 4, t));
         s.in_domain    = (regs[qbte_pkg::REG_START_TIME] <= q) &&
                          (q <= regs[qbte_pkg::REG_END_TIME]);
         due_samples.push_back(s);
      endfunction

      task compare_field(string field, logic signed [qbte_pkg::DATA_W-1:0] q,
                         logic [qbte_pkg::DATA_W-1:0] got, logic [qbte_pkg::DATA_W-1:0] want);
         if (got !== want) begin
            report($sformatf("query %h %s: got %h expected %h", q, field, got, want));
         end
      endtask

      // Compares one accepted result with the oldest outstanding sample.
      task check_sample(logic signed [qbte_pkg::DATA_W-1:0] pos,
                        logic signed [qbte_pkg::DATA_W-1:0] vel,
                        logic signed [qbte_pkg::DATA_W-1:0] accel, logic dom);
         blend_sample_type s;
         if (due_samples.size() == 0) begin
            report($sformatf("result %h/%h/%h/%b with no query outstanding",
                             pos, vel, accel, dom));
            return;
         end
         s = due_samples.pop_front();
         compare_field("position", s.query, pos, s.position);
         compare_field("velocity", s.query, vel, s.velocity);
         compare_field("acceleration", s.query, accel, s.acceleration);
         compare_field("in_domain", s.query, 32'(dom), 32'(s.in_domain));
      endtask
   endclass

   logic                                 clock;
   logic                                 reset;
   logic                                 req_valid;
   logic                                 req_stall;
   logic signed [qbte_pkg::DATA_W-1:0]   req_query_time;
   logic                                 rsp_valid;
   logic                                 rsp_stall;
   logic signed [qbte_pkg::DATA_W-1:0]   rsp_position;
   logic signed [qbte_pkg::DATA_W-1:0]   rsp_velocity;
   logic signed [qbte_pkg::DATA_W-1:0]   rsp_acceleration;
   logic                                 rsp_in_domain;
   logic                                 csr_wr_en;
   logic [qbte_pkg::REG_IDX_W-1:0]       csr_index;
   logic [qbte_pkg::DATA_W-1:0]          csr_wdata;

   blend_checker  board = new();
   blend_cfg_type next_cfg;
   traffic_type   traffic = TRAFFIC_QUIET;
   int            cycle_count = 0;

   quintic_blend_trajectory_eval_core DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_query_time   (req_query_time),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_position     (rsp_position),
      .rsp_velocity     (rsp_velocity),
      .rsp_acceleration (rsp_acceleration),
      .rsp_in_domain    (rsp_in_domain),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // The run is bounded by a cycle count well above the slowest legal run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Result monitor. Signals are read right after the edge, so they hold the values that the
   // block saw at that edge; a transaction completes when valid is high and stall is low.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         board.check_sample(rsp_position, rsp_velocity, rsp_acceleration, rsp_in_domain);
      end
   end

   // Receiver back-pressure. The stall level is held for runs of random length; heavy
   // traffic adds frequent short stalls and the occasional long one, quiet traffic none.
   initial begin : rsp_stall_driver
      int   run;
      int   r;
      logic level;
      run = 0;
      level = 1'b0;
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (run > 0) begin
            run--;
         end else if (traffic == TRAFFIC_QUIET) begin
            level = 1'b0;
            run = $urandom_range(8, 1);
         end else begin
            r = $urandom_range(99);
            if (r < ((traffic == TRAFFIC_HEAVY) ? 3 : 1)) begin
               level = 1'b1;
               run = $urandom_range(60, 20);
            end else if (r < ((traffic == TRAFFIC_HEAVY) ? 50 : 20)) begin
               level = 1'b1;
               run = $urandom_range(3);
            end else begin
               level = 1'b0;
               run = $urandom_range(4);
            end
         end
         rsp_stall <= level;
      end
   end

   function automatic int rand_between(int lo, int hi);
      return lo + int'($urandom_range(hi - lo));
   endfunction

   // Sender idle time after a transaction: none in quiet traffic, otherwise often none, sometimes short, rarely long.
   function automatic int next_gap();
      int r;
      r = $urandom_range(99);
      if (traffic == TRAFFIC_QUIET) return 0;
      if (r < ((traffic == TRAFFIC_HEAVY) ? 40 : 75)) return 0;
      if (r < 95) return $urandom_range(3, 1);
      return $urandom_range(40, 10);
   endfunction

   function automatic logic signed [qbte_pkg::DATA_W-1:0] pick_corner();
      case ($urandom_range(5))
         0: return S32_MAX;
         1: return S32_MIN;
         2: return '0;
         3: return -1;
         4: return 1;
         default: return $urandom;
      endcase
   endfunction

   // Most queries land around the blend window, some on its edges, the rest anywhere.
   function automatic logic signed [qbte_pkg::DATA_W-1:0] pick_query();
      int r;
      r = $urandom_range(99);
      if (r < 80) return next_cfg[qbte_pkg::REG_START_TIME] +
                         rand_between(-BLEND_SPAN / 2, 3 * BLEND_SPAN / 2);
      if (r < 85) return next_cfg[qbte_pkg::REG_START_TIME];
      if (r < 90) return next_cfg[qbte_pkg::REG_END_TIME] + rand_between(-1, 1);
      return $urandom;
   endfunction

   // A physically plausible blend: moderate positions, rates and accelerations, the nominal
   // span most of the time, and now and then an odd span or a reversed interval.
   task automatic pick_realistic_blend();
      int span;
      next_cfg[qbte_pkg::REG_START_TIME] = rand_between(-(1 << 26), 1 << 26);
      case ($urandom_range(7))
         0: span = -rand_between(0, Q_ONE);
         1, 2: span = rand_between(0, Q_ONE);
         default: span = BLEND_SPAN;
      endcase
      next_cfg[qbte_pkg::REG_END_TIME]       = next_cfg[qbte_pkg::REG_START_TIME] + span;
      next_cfg[qbte_pkg::REG_START_POSITION] = rand_between(-100 * Q_ONE, 100 * Q_ONE);
      next_cfg[qbte_pkg::REG_END_POSITION]   = rand_between(-100 * Q_ONE, 100 * Q_ONE);
      next_cfg[qbte_pkg::REG_START_RATE]     = rand_between(-10 * Q_ONE, 10 * Q_ONE);
      next_cfg[qbte_pkg::REG_END_RATE]       = rand_between(-10 * Q_ONE, 10 * Q_ONE);
      next_cfg[qbte_pkg::REG_START_ACCEL]    = rand_between(-100 * Q_ONE, 100 * Q_ONE);
      next_cfg[qbte_pkg::REG_END_ACCEL]      = rand_between(-100 * Q_ONE, 100 * Q_ONE);
   endtask

   // Writes every register from next_cfg, one per cycle, and keeps the mirror in step.
   task automatic load_blend();
      qbte_pkg::qbte_reg_type idx;
      idx = idx.first();
      do begin
         csr_wr_en <= 1'b1;
         csr_index <= idx;
         csr_wdata <= next_cfg[idx];
         @(posedge clock);
         board.set_reg(idx, next_cfg[idx]);
         idx = idx.next();
      end while (idx != idx.first());
      csr_wr_en <= 1'b0;
   endtask

   // Presents one query and holds it until the block takes it.
   task automatic send_query(input logic signed [qbte_pkg::DATA_W-1:0] q);
      int gap;
      req_valid <= 1'b1;
      req_query_time <= q;
      do @(posedge clock); while (req_stall);
      board.note_query(q);
      gap = next_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Stops sending and waits until every predicted sample has come back, then lets the
   // pipeline settle so that a configuration write cannot overtake a transaction.
   task automatic drain_results();
      int waited;
      waited = 0;
      req_valid <= 1'b0;
      while (board.due_samples.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (board.due_samples.size() != 0) begin
         board.report($sformatf("%0d results never arrived", board.due_samples.size()));
         board.due_samples.delete();
      end
   endtask

   initial begin : stimulus
      int phase;
      int random_sent;
      int count;
      int i;
      reset = 1'b1;
      req_valid = 1'b0;
      req_query_time = '0;
      csr_wr_en = 1'b0;
      csr_index = qbte_pkg::REG_START_TIME;
      csr_wdata = '0;
      foreach (next_cfg[k]) next_cfg[k] = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      traffic = TRAFFIC_LIGHT;

      // With the reset configuration every coefficient is zero; only the domain flag
      // depends on the query, and it is set only for a query of exactly zero.
      send_query('0);
      send_query(S32_MAX);
      send_query(S32_MIN);
      send_query(-1);
      send_query(1);
      drain_results();

      // A nominal blend starting at 1 s; probe the window edges, the middle, one step
      // outside either edge, and the extremes of the time range.
      next_cfg[qbte_pkg::REG_START_TIME]     = Q_ONE;
      next_cfg[qbte_pkg::REG_END_TIME]       = Q_ONE + BLEND_SPAN;
      next_cfg[qbte_pkg::REG_START_POSITION] = 2 * Q_ONE;
      next_cfg[qbte_pkg::REG_START_RATE]     = Q_ONE / 2;
      next_cfg[qbte_pkg::REG_START_ACCEL]    = -Q_ONE;
      next_cfg[qbte_pkg::REG_END_POSITION]   = 3 * Q_ONE;
      next_cfg[qbte_pkg::REG_END_RATE]       = '0;
      next_cfg[qbte_pkg::REG_END_ACCEL]      = Q_ONE;
      load_blend();
      send_query(Q_ONE);
      send_query(Q_ONE + BLEND_SPAN);
      send_query(Q_ONE + BLEND_SPAN / 2);
      send_query(Q_ONE - 1);
      send_query(Q_ONE + BLEND_SPAN + 1);
      send_query(S32_MIN);
      send_query(S32_MAX);
      drain_results();

      // Reversed interval: the polynomial is still evaluated but the flag stays low.
      next_cfg[qbte_pkg::REG_START_TIME] = 2 * Q_ONE;
      next_cfg[qbte_pkg::REG_END_TIME]   = Q_ONE;
      load_blend();
      send_query(3 * Q_ONE / 2);
      send_query(2 * Q_ONE);
      send_query(Q_ONE);
      drain_results();

      // Full-scale registers drive every lane into saturation.
      next_cfg[qbte_pkg::REG_START_TIME]     = S32_MIN;
      next_cfg[qbte_pkg::REG_END_TIME]       = S32_MAX;
      next_cfg[qbte_pkg::REG_START_POSITION] = S32_MAX;
      next_cfg[qbte_pkg::REG_START_RATE]     = S32_MIN;
      next_cfg[qbte_pkg::REG_START_ACCEL]    = S32_MAX;
      next_cfg[qbte_pkg::REG_END_POSITION]   = S32_MIN;
      next_cfg[qbte_pkg::REG_END_RATE]       = S32_MAX;
      next_cfg[qbte_pkg::REG_END_ACCEL]      = S32_MIN;
      load_blend();
      send_query(S32_MIN);
      send_query(S32_MAX);
      send_query('0);
      drain_results();

      // The mirror image, which also makes the widest reversed interval.
      next_cfg[qbte_pkg::REG_START_TIME]     = S32_MAX;
      next_cfg[qbte_pkg::REG_END_TIME]       = S32_MIN;
      next_cfg[qbte_pkg::REG_START_POSITION] = S32_MIN;
      next_cfg[qbte_pkg::REG_START_RATE]     = S32_MAX;
      next_cfg[qbte_pkg::REG_START_ACCEL]    = S32_MIN;
      next_cfg[qbte_pkg::REG_END_POSITION]   = S32_MAX;
      next_cfg[qbte_pkg::REG_END_RATE]       = S32_MIN;
      next_cfg[qbte_pkg::REG_END_ACCEL]      = S32_MAX;
      load_blend();
      send_query(S32_MAX);
      send_query(S32_MIN);
      send_query('0);
      send_query(-1);

      // Random phases. Each one loads a fresh configuration while the block is idle,
      // then streams queries under one traffic pattern. Every other phase also stops
      // halfway and waits until all outstanding results have come back.
      phase = 0;
      random_sent = 0;
      while (random_sent < RANDOM_QUERIES) begin
         drain_results();
         case (phase % 4)
            2: foreach (next_cfg[k]) next_cfg[k] = $urandom;
            3: foreach (next_cfg[k]) next_cfg[k] = pick_corner();
            default: pick_realistic_blend();
         endcase
         load_blend();
         traffic = traffic_type'(phase % 3);
         count = $urandom_range(260, 120);
         if (count > RANDOM_QUERIES - random_sent) count = RANDOM_QUERIES - random_sent;
         for (i = 0; i < count; i++) begin
            if (i == count / 2 && phase % 2 == 0) drain_results();
            send_query(pick_query());
            random_sent++;
         end
         phase++;
      end

      drain_results();
      if (board.mismatches == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
